// ===== sv/spq_pkg.sv =====
package spq_pkg;

    // Default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int TAG_BITS_DEF   = 16;
    localparam int LEVEL_BITS_DEF = 8;

    // Fixed result field widths
    localparam int POS_BITS    = 4;
    localparam int STATUS_BITS = 2;

    // Command codes (input tuser)
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Result status codes (output tuser)
    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_READ     = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd3;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic ins;   // insert a new entry this cycle
        logic rot;   // rotate the occupied cells toward the head
        logic occ;   // this cell holds a stored entry
        logic tail;  // this cell is the last occupied one
    } t_cell_ctl;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell #(
    parameter int TAG_BITS   = spq_pkg::TAG_BITS_DEF,
    parameter int LEVEL_BITS = spq_pkg::LEVEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic [TAG_BITS-1:0]   i_new_tag,
    input  logic [LEVEL_BITS-1:0] i_new_level,
    input  logic                  i_prev_gt,
    input  logic [TAG_BITS-1:0]   i_prev_tag,
    input  logic [LEVEL_BITS-1:0] i_prev_level,
    input  logic [TAG_BITS-1:0]   i_next_tag,
    input  logic [LEVEL_BITS-1:0] i_next_level,
    input  logic [TAG_BITS-1:0]   i_head_tag,
    input  logic [LEVEL_BITS-1:0] i_head_level,
    output logic                  o_gt,
    output logic [TAG_BITS-1:0]   o_tag,
    output logic [LEVEL_BITS-1:0] o_level
);
    import spq_pkg::*;

    logic [TAG_BITS-1:0]   r_tag;
    logic [LEVEL_BITS-1:0] r_level;
    logic [TAG_BITS-1:0]   n_tag;
    logic [LEVEL_BITS-1:0] n_level;

    // Stored entry ranks strictly after the new one
    assign o_gt = i_ctl.occ && (r_level > i_new_level);

    // Pick the next content: shift right on insert, rotate left on readout
    always_comb begin
        n_tag   = r_tag;
        n_level = r_level;
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_tag   = i_prev_tag;
                n_level = i_prev_level;
            end else if (o_gt || !i_ctl.occ) begin
                n_tag   = i_new_tag;
                n_level = i_new_level;
            end
        end else if (i_ctl.rot && i_ctl.occ) begin
            if (i_ctl.tail) begin
                n_tag   = i_head_tag;
                n_level = i_head_level;
            end else begin
                n_tag   = i_next_tag;
                n_level = i_next_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= n_tag;
        r_level <= n_level;
    end

    assign o_tag   = r_tag;
    assign o_level = r_level;

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// Stable sorted priority queue built as a row of DEPTH cells, head in cell 0,
// lowest level first; entries of equal level keep their arrival order. An
// insert beat (tuser 0) compares the new level against every cell at once and
// shifts the tail end right as it is taken, answering with one result beat
// (status 0, or status 1 when full). A read beat (tuser 1) streams all stored
// entries from the head, one result beat per cycle while the receiver is ready,
// with their position and tlast on the final one; the row rotates one step per
// beat and is back in place after the last. A read of an empty queue gives one
// status 3 beat. A read sends one beat per stored entry through the single
// head port of the cell row. Input is held off while a read is streaming.
// Reading does not remove entries.
module sorted_priority_queue_core #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int TAG_BITS   = spq_pkg::TAG_BITS_DEF,
    parameter int LEVEL_BITS = spq_pkg::LEVEL_BITS_DEF,
    localparam int IN_DW  = ((TAG_BITS + LEVEL_BITS + 7) / 8) * 8,
    localparam int OUT_DW = ((TAG_BITS + LEVEL_BITS + spq_pkg::POS_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_DW-1:0]                s_axis_tdata,  // tag, level
    input  logic                            s_axis_tuser,  // cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_DW-1:0]               m_axis_tdata,  // out_tag, out_level, position
    output logic [spq_pkg::STATUS_BITS-1:0] m_axis_tuser,  // status
    output logic                            m_axis_tlast
);
    import spq_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OUT_FW = TAG_BITS + LEVEL_BITS + POS_BITS;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    // Input beat fields
    logic [TAG_BITS-1:0]   w_in_tag;
    logic [LEVEL_BITS-1:0] w_in_level;
    assign w_in_tag   = s_axis_tdata[TAG_BITS-1:0];
    assign w_in_level = s_axis_tdata[TAG_BITS +: LEVEL_BITS];

    // Control state
    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;

    // Output register
    logic                   r_ovalid, n_ovalid;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic [TAG_BITS-1:0]    r_otag, n_otag;
    logic [LEVEL_BITS-1:0]  r_olevel, n_olevel;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic                   r_olast, n_olast;

    logic w_out_free, w_accept, w_ins, w_rot;

    // Cell row links
    logic                  w_gt    [DEPTH];
    logic [TAG_BITS-1:0]   w_tag   [DEPTH];
    logic [LEVEL_BITS-1:0] w_level [DEPTH];

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Sequence inserts and readouts
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_status = r_status;
        n_otag   = r_otag;
        n_olevel = r_olevel;
        n_pos    = r_pos;
        n_olast  = r_olast;
        w_ins    = 1'b0;
        w_rot    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    n_otag   = '0;
                    n_olevel = '0;
                    n_pos    = '0;
                    n_olast  = 1'b1;
                    if (s_axis_tuser == CMD_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_INSERTED;
                            w_ins    = 1'b1;
                            n_count  = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // emit the head now and rotate
                        n_status = ST_READ;
                        n_otag   = w_tag[0];
                        n_olevel = w_level[0];
                        w_rot    = 1'b1;
                        n_olast  = (r_count == CNT_W'(1));
                        n_idx    = CNT_W'(1);
                        if (r_count != CNT_W'(1)) begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_status = ST_READ;
                    n_otag   = w_tag[0];
                    n_olevel = w_level[0];
                    n_pos    = POS_BITS'(r_idx);
                    w_rot    = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_olast  = (r_idx == CNT_W'(r_count - 1'b1));
                    if (n_olast) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_otag   <= n_otag;
        r_olevel <= n_olevel;
        r_pos    <= n_pos;
        r_olast  <= n_olast;
    end

    // Build the cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_cell_ctl             w_ctl;
        logic                  w_pgt;
        logic [TAG_BITS-1:0]   w_ptag, w_ntag;
        logic [LEVEL_BITS-1:0] w_plevel, w_nlevel;

        assign w_ctl.ins  = w_ins;
        assign w_ctl.rot  = w_rot;
        assign w_ctl.occ  = (CNT_W'(i) < r_count);
        assign w_ctl.tail = (CNT_W'(i + 1) == r_count);

        if (i == 0) begin : g_head
            assign w_pgt    = 1'b0;
            assign w_ptag   = w_in_tag;
            assign w_plevel = w_in_level;
        end else begin : g_body
            assign w_pgt    = w_gt[i-1];
            assign w_ptag   = w_tag[i-1];
            assign w_plevel = w_level[i-1];
        end

        if (i == DEPTH - 1) begin : g_end
            assign w_ntag   = w_tag[0];
            assign w_nlevel = w_level[0];
        end else begin : g_mid
            assign w_ntag   = w_tag[i+1];
            assign w_nlevel = w_level[i+1];
        end

        spq_cell #(
            .TAG_BITS   (TAG_BITS),
            .LEVEL_BITS (LEVEL_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_new_tag    (w_in_tag),
            .i_new_level  (w_in_level),
            .i_prev_gt    (w_pgt),
            .i_prev_tag   (w_ptag),
            .i_prev_level (w_plevel),
            .i_next_tag   (w_ntag),
            .i_next_level (w_nlevel),
            .i_head_tag   (w_tag[0]),
            .i_head_level (w_level[0]),
            .o_gt         (w_gt[i]),
            .o_tag        (w_tag[i]),
            .o_level      (w_level[i])
        );
    end

    // Drive the result beat
    always_comb begin
        m_axis_tdata             = '0;
        m_axis_tdata[OUT_FW-1:0] = {r_pos, r_olevel, r_otag};
    end
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_olast;

endmodule

// ===== test/sorted_priority_queue_core_checker.sv =====
module sorted_priority_queue_core_checker #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int TAG_BITS   = spq_pkg::TAG_BITS_DEF,
    parameter int LEVEL_BITS = spq_pkg::LEVEL_BITS_DEF,
    parameter int IN_DW      = 24,
    parameter int OUT_DW     = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [IN_DW-1:0]                i_in_data,    // tag, level
    input  logic                            i_in_cmd,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [OUT_DW-1:0]               i_out_data,   // out_tag, out_level, position
    input  logic [spq_pkg::STATUS_BITS-1:0] i_out_status,
    input  logic                            i_out_last,
    output int                              o_errors,
    output int                              o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TAG_BITS-1:0]    tag;
        logic [LEVEL_BITS-1:0]  level;
        logic [POS_BITS-1:0]    pos;
        logic                   last;
    } t_result;

    // Shadow copy of the sorted store, head in entry 0
    logic [TAG_BITS-1:0]   model_tag [DEPTH];
    logic [LEVEL_BITS-1:0] model_level [DEPTH];
    int                    model_fill;

    t_result pending_results[$];
    t_result got;
    t_result want;

    // Format one result beat for messages
    function automatic string fmt_result(input t_result r);
        return $sformatf("status %0d tag %h level %h pos %0d last %0b",
                         r.status, r.tag, r.level, r.pos, r.last);
    endfunction

    // Update the shadow store for one command and queue the beats it causes
    task automatic apply_queue_op(input logic cmd, input logic [TAG_BITS-1:0] tag,
                                  input logic [LEVEL_BITS-1:0] level);
        int      slot;
        t_result r;
        r = '0;
        r.last = 1'b1;
        if (cmd == CMD_INSERT) begin
            if (model_fill >= DEPTH) begin
                r.status = ST_FULL;
                pending_results.push_back(r);
            end else begin
                // land after every entry of lower or equal level
                slot = model_fill;
                for (int i = model_fill - 1; i >= 0; i--) begin
                    if (model_level[i] > level) slot = i;
                end
                for (int i = model_fill; i > slot; i--) begin
                    model_tag[i]   = model_tag[i-1];
                    model_level[i] = model_level[i-1];
                end
                model_tag[slot]   = tag;
                model_level[slot] = level;
                model_fill++;
                r.status = ST_INSERTED;
                pending_results.push_back(r);
            end
        end else if (model_fill == 0) begin
            r.status = ST_EMPTY;
            pending_results.push_back(r);
        end else begin
            for (int i = 0; i < model_fill; i++) begin
                r.status = ST_READ;
                r.tag    = model_tag[i];
                r.level  = model_level[i];
                r.pos    = POS_BITS'(i);
                r.last   = (i == model_fill - 1);
                pending_results.push_back(r);
            end
        end
    endtask

    // Predict on input beats, then compare output beats with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_fill = 0;
            pending_results.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_queue_op(i_in_cmd, i_in_data[TAG_BITS-1:0],
                               i_in_data[TAG_BITS +: LEVEL_BITS]);
            end
            if (i_out_valid && i_out_ready) begin
                got.status = i_out_status;
                got.tag    = i_out_data[TAG_BITS-1:0];
                got.level  = i_out_data[TAG_BITS +: LEVEL_BITS];
                got.pos    = i_out_data[TAG_BITS+LEVEL_BITS +: POS_BITS];
                got.last   = i_out_last;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected beat: %s", $realtime, fmt_result(got));
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch: expected %s, actual %s",
                                 $realtime, fmt_result(want), fmt_result(got));
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ===== test/sorted_priority_queue_core_tb.sv =====
module sorted_priority_queue_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int TAG_BITS   = TAG_BITS_DEF;
    localparam int LEVEL_BITS = LEVEL_BITS_DEF;
    localparam int IN_DW      = ((TAG_BITS + LEVEL_BITS + 7) / 8) * 8;
    localparam int OUT_DW     = ((TAG_BITS + LEVEL_BITS + POS_BITS + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_OPS = 360;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DW-1:0]       s_axis_tdata;   // tag, level
    logic                   s_axis_tuser;   // cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DW-1:0]      m_axis_tdata;   // out_tag, out_level, position
    logic [STATUS_BITS-1:0] m_axis_tuser;   // status
    logic                   m_axis_tlast;

    int error_count;
    int results_due;
    int burst_left;
    bit sender_steady;
    int idle_cycles;

    sorted_priority_queue_core #(
        .DEPTH      (DEPTH),
        .TAG_BITS   (TAG_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sorted_priority_queue_core_checker #(
        .DEPTH      (DEPTH),
        .TAG_BITS   (TAG_BITS),
        .LEVEL_BITS (LEVEL_BITS),
        .IN_DW      (IN_DW),
        .OUT_DW     (OUT_DW)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_cmd     (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_status (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_errors     (error_count),
        .o_pending    (results_due)
    );

    // Clock: 4 ns period
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Send one beat, opening a new burst after a random gap when the last one ran out
    task automatic send_beat(input logic cmd, input logic [TAG_BITS-1:0] tag,
                             input logic [LEVEL_BITS-1:0] level);
        int gap;
        if (burst_left == 0) begin
            gap = (sender_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk) s_axis_tvalid <= 1'b0;
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DW'({level, tag});
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Receiver stalls: rotate through always-ready, coin-flip, one-in-four and stall runs
    initial begin : rx_stall
        int rx_cycle;
        int stall_left;
        rx_cycle   = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            case ((rx_cycle / 97) % 4)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_axis_tready <= (rx_cycle % 4 == 0);
                end
                default: begin
                    if (stall_left > 0) begin
                        m_axis_tready <= 1'b0;
                        stall_left--;
                    end else begin
                        m_axis_tready <= 1'b1;
                        if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 10);
                    end
                end
            endcase
            rx_cycle++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired", $realtime);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic                  cmd;
        logic [LEVEL_BITS-1:0] level;
        logic [LEVEL_BITS-1:0] tie_levels [4];
        tie_levels    = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_INSERT;
        m_axis_tready = 1'b0;
        burst_left    = 0;
        sender_steady = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Read the empty queue
        send_beat(CMD_READ, 16'h0000, 8'h00);
        // Extremes of tag and level, ties at both ends and in the middle
        send_beat(CMD_INSERT, 16'hFFFF, 8'hFF);
        send_beat(CMD_READ, 16'hFFFF, 8'hFF);
        send_beat(CMD_INSERT, 16'h0000, 8'h00);
        send_beat(CMD_INSERT, 16'h5555, 8'h80);
        send_beat(CMD_INSERT, 16'hAAAA, 8'h80);
        send_beat(CMD_READ, 16'h1234, 8'h55);
        send_beat(CMD_INSERT, 16'h0001, 8'hFF);
        send_beat(CMD_INSERT, 16'h8000, 8'h00);
        send_beat(CMD_INSERT, 16'h00FF, 8'h7F);
        send_beat(CMD_READ, 16'h0000, 8'h00);

        // Random mix: fill the store with ties and spread levels, then hit it full
        for (int n = 0; n < RANDOM_OPS; n++) begin
            sender_steady = (n >= 120 && n < 190);
            cmd = ($urandom_range(0, 2) == 0) ? CMD_READ : CMD_INSERT;
            if ($urandom_range(0, 1) == 0)
                level = tie_levels[$urandom_range(0, 3)];
            else
                level = LEVEL_BITS'($urandom_range(0, 255));
            send_beat(cmd, TAG_BITS'($urandom), level);
        end

        // Drain and settle
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (error_count == 0 && results_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
